/* hw/rtl/md5_pkg.sv */
// Package: shared types and constants of the MD5 digest block.
`timescale 1ns / 1ps
package md5_pkg;

    localparam logic [1:0] CMD_BYTE     = 2'd0;
    localparam logic [1:0] CMD_BYTE_END = 2'd1;
    localparam logic [1:0] CMD_END      = 2'd2;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LEN_POS = 6'd56;

    // Byte source for a buffer write.
    localparam logic [1:0] WSRC_DATA = 2'd0;
    localparam logic [1:0] WSRC_PAD  = 2'd1;
    localparam logic [1:0] WSRC_ZERO = 2'd2;
    localparam logic [1:0] WSRC_LEN  = 2'd3;

    // Controller to datapath commands.
    typedef struct packed {
        logic       wr_en;      // write one byte into the block buffer
        logic [1:0] wr_src;
        logic [5:0] wr_addr;
        logic       cnt_inc;    // advance message byte count
        logic       rd_en;      // read a word (address = word index of rd_idx)
        logic [5:0] rd_idx;     // round whose message word is fetched
        logic       rnd_load;   // copy chain words into working regs
        logic       rnd_en;     // run one round
        logic [5:0] rnd_idx;
        logic       ff_en;      // feed-forward add into chain words
        logic       msg_init;   // restore initial chain, clear count
    } t_cmd;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
            6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
            6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
            6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] round_s(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
            4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
            4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
        endcase
        return s;
    endfunction

    // Message word index used by round i.
    function automatic logic [3:0] round_g(input logic [5:0] i);
        logic [3:0] g;
        case (i[5:4])
            2'd0: g = i[3:0];
            2'd1: g = 4'(5 * i[3:0] + 1);
            2'd2: g = 4'(3 * i[3:0] + 5);
            default: g = 4'(7 * i[3:0]);
        endcase
        return g;
    endfunction

endpackage

/* hw/rtl/md5_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module md5_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule

/* hw/rtl/md5_datapath.sv */
// Datapath: block buffer (four byte-lane RAMs), byte count, round unit, chain words.
`timescale 1ns / 1ps
module md5_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  md5_pkg::t_cmd i_cmd,
    input  logic [7:0]    i_data_byte,
    output logic [31:0]   o_digest_a,
    output logic [31:0]   o_digest_b,
    output logic [31:0]   o_digest_c,
    output logic [31:0]   o_digest_d
);
    logic [60:0] r_count;
    logic [31:0] r_ha, r_hb, r_hc, r_hd;
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [7:0]  w_wr_byte;
    logic [63:0] w_bits;
    logic [31:0] w_word;
    logic [31:0] w_f, w_t, w_rot, w_newb;
    logic [4:0]  w_s;

    assign w_bits = {r_count, 3'b000};

    always_comb begin
        case (i_cmd.wr_src)
            md5_pkg::WSRC_DATA: w_wr_byte = i_data_byte;
            md5_pkg::WSRC_PAD:  w_wr_byte = md5_pkg::PAD_BYTE;
            md5_pkg::WSRC_ZERO: w_wr_byte = 8'h00;
            default:            w_wr_byte = w_bits[{i_cmd.wr_addr[2:0], 3'b000} +: 8];
        endcase
    end

    // Byte lane j of word w sits in lane RAM j at address w.
    for (genvar j = 0; j < 4; j++) begin : g_lane
        md5_ram #(.WIDTH(8), .DEPTH(16)) u_ram (
            .i_clk     (i_clk),
            .i_wr_en   (i_cmd.wr_en && (i_cmd.wr_addr[1:0] == 2'(j))),
            .i_wr_addr (i_cmd.wr_addr[5:2]),
            .i_wr_data (w_wr_byte),
            .i_rd_en   (i_cmd.rd_en),
            .i_rd_addr (md5_pkg::round_g(i_cmd.rd_idx)),
            .o_rd_data (w_word[8*j +: 8])
        );
    end

    always_comb begin
        case (i_cmd.rnd_idx[5:4])
            2'd0: w_f = r_d ^ (r_b & (r_c ^ r_d));
            2'd1: w_f = r_c ^ (r_d & (r_b ^ r_c));
            2'd2: w_f = r_b ^ r_c ^ r_d;
            default: w_f = r_c ^ (r_b | ~r_d);
        endcase
        w_s    = md5_pkg::round_s(i_cmd.rnd_idx);
        w_t    = r_a + w_f + w_word + md5_pkg::round_k(i_cmd.rnd_idx);
        w_rot  = (w_t << w_s) | (w_t >> (6'd32 - {1'b0, w_s}));
        w_newb = r_b + w_rot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.msg_init) begin
            r_count <= '0;
            r_ha <= md5_pkg::INIT_A;
            r_hb <= md5_pkg::INIT_B;
            r_hc <= md5_pkg::INIT_C;
            r_hd <= md5_pkg::INIT_D;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + 61'd1;
            end
            if (i_cmd.ff_en) begin
                r_ha <= r_ha + r_a;
                r_hb <= r_hb + r_b;
                r_hc <= r_hc + r_c;
                r_hd <= r_hd + r_d;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rnd_load) begin
            r_a <= r_ha; r_b <= r_hb; r_c <= r_hc; r_d <= r_hd;
        end else if (i_cmd.rnd_en) begin
            r_a <= r_d; r_d <= r_c; r_c <= r_b; r_b <= w_newb;
        end
    end

    assign o_digest_a = r_ha;
    assign o_digest_b = r_hb;
    assign o_digest_c = r_hc;
    assign o_digest_d = r_hd;
endmodule

/* hw/rtl/md5_ctrl.sv */
// Controller: byte intake, padding sequence, round sequencing, output handshake.
`timescale 1ns / 1ps
module md5_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [1:0]    i_cmd,
    output logic          o_valid,
    input  logic          i_ready,
    output md5_pkg::t_cmd o_dp
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;  // writing pad/zero/length bytes
    localparam logic [2:0] ST_RND  = 3'd2;  // 64 rounds
    localparam logic [2:0] ST_FF   = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0] r_state, n_state;
    logic [5:0] r_fill, n_fill;   // bytes in block
    logic [5:0] r_ptr, n_ptr;     // pad write pointer
    logic [6:0] r_rnd, n_rnd;     // round counter incl. prefetch step
    logic       r_fin, n_fin;     // finishing a message
    logic       r_pad1, n_pad1;   // 0x80 byte still to be written
    logic       r_last, n_last;   // this compression is the final one
    logic       w_acc;

    assign o_ready = (r_state == ST_IDLE) && !o_valid;
    assign w_acc   = i_valid && o_ready;

    always_comb begin
        n_state = r_state; n_fill = r_fill; n_ptr = r_ptr; n_rnd = r_rnd;
        n_fin = r_fin; n_pad1 = r_pad1; n_last = r_last;
        o_dp = '0;
        o_dp.rnd_idx = r_rnd[5:0];
        case (r_state)
            ST_IDLE: begin
                if (w_acc && (i_cmd == md5_pkg::CMD_BYTE || i_cmd == md5_pkg::CMD_BYTE_END)) begin
                    o_dp.wr_en   = 1'b1;
                    o_dp.wr_src  = md5_pkg::WSRC_DATA;
                    o_dp.wr_addr = r_fill;
                    o_dp.cnt_inc = 1'b1;
                    n_fill = r_fill + 6'd1;
                    n_fin  = (i_cmd == md5_pkg::CMD_BYTE_END);
                    n_pad1 = 1'b1;
                    n_ptr  = r_fill + 6'd1;
                    if (r_fill == 6'd63) begin
                        n_state = ST_RND; n_rnd = '0; n_last = 1'b0;
                    end else if (n_fin) begin
                        n_state = ST_PAD;
                    end
                end else if (w_acc && i_cmd == md5_pkg::CMD_END) begin
                    n_fin = 1'b1; n_pad1 = 1'b1; n_ptr = r_fill; n_state = ST_PAD;
                end
            end
            ST_PAD: begin
                o_dp.wr_en   = 1'b1;
                o_dp.wr_addr = r_ptr;
                n_ptr  = r_ptr + 6'd1;
                n_pad1 = 1'b0;
                if (r_pad1) begin
                    o_dp.wr_src = md5_pkg::WSRC_PAD;
                end else if (r_ptr >= md5_pkg::LEN_POS && r_last) begin
                    o_dp.wr_src = md5_pkg::WSRC_LEN;
                end else begin
                    o_dp.wr_src = md5_pkg::WSRC_ZERO;
                end
                // Length goes in only if the 0x80 landed before byte 56.
                if (r_pad1) begin
                    n_last = (r_ptr < md5_pkg::LEN_POS);
                end
                if (r_ptr == 6'd63) begin
                    n_state = ST_RND; n_rnd = '0;
                end
            end
            ST_RND: begin
                // Step 0 loads working regs and fetches word; steps 1..64 run rounds.
                o_dp.rnd_load = (r_rnd == 7'd0);
                o_dp.rnd_en   = (r_rnd != 7'd0);
                o_dp.rnd_idx  = (r_rnd == 7'd0) ? 6'd0 : r_rnd[5:0] - 6'd1;
                o_dp.rd_en    = 1'b1;
                if (r_rnd != 7'd64) begin
                    o_dp.rnd_idx = (r_rnd == 7'd0) ? 6'd0 : r_rnd[5:0] - 6'd1;
                end else begin
                    o_dp.rnd_idx = 6'd63;
                end
                // Read address runs one round ahead of the round unit.
                o_dp.rd_idx = r_rnd[5:0];
                n_rnd = r_rnd + 7'd1;
                if (r_rnd == 7'd64) begin
                    n_state = ST_FF;
                end
            end
            ST_FF: begin
                o_dp.ff_en = 1'b1;
                n_fill = '0;
                if (!r_fin) begin
                    n_state = ST_IDLE;
                end else if (r_last) begin
                    n_state = ST_OUT;
                end else begin
                    n_ptr = '0; n_last = 1'b1; n_state = ST_PAD;
                end
            end
            ST_OUT: begin
                if (i_ready) begin
                    o_dp.msg_init = 1'b1;
                    n_fin = 1'b0; n_last = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_valid = (r_state == ST_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_fill <= '0; r_ptr <= '0; r_rnd <= '0;
            r_fin <= 1'b0; r_pad1 <= 1'b0; r_last <= 1'b0;
        end else begin
            r_state <= n_state; r_fill <= n_fill; r_ptr <= n_ptr; r_rnd <= n_rnd;
            r_fin <= n_fin; r_pad1 <= n_pad1; r_last <= n_last;
        end
    end
endmodule

/* hw/rtl/md5_message_digest.sv */
// Top level: MD5 digest engine, controller plus datapath.
`timescale 1ns / 1ps
// A byte that fills a block starts a compression: word fetch, 64 rounds, feed-forward.
// Other bytes are written straight into the block buffer; a message end adds padding
// writes and one or two compressions before the digest transaction is offered.
// No byte is accepted while the single shared round unit works or a digest waits.
// Reset (synchronous, active low) restores the initial chain words and clears counts.
module md5_message_digest (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_a,
    output logic [31:0] o_digest_b,
    output logic [31:0] o_digest_c,
    output logic [31:0] o_digest_d
);
    md5_pkg::t_cmd w_dp;

    // Controller sequences padding and rounds; the digest stays in the
    // chain registers until the output transaction completes.
    md5_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_cmd   (i_cmd),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_dp    (w_dp)
    );

    md5_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_dp),
        .i_data_byte (i_data_byte),
        .o_digest_a  (o_digest_a),
        .o_digest_b  (o_digest_b),
        .o_digest_c  (o_digest_c),
        .o_digest_d  (o_digest_d)
    );
endmodule

/* hw/rtl/md5_checker.sv */
// Port-level checker for the MD5 digest block, bound to the top level.
`timescale 1ns / 1ps
module md5_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_digest_a
);
    // No input accepted while a digest waits.
    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("input ready while digest pending");

    // Digest stays stable while stalled.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_digest_a))
        else $error("digest changed while stalled");

    // After a digest transaction, ready returns next cycle.
    a_ready_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready |=> o_ready) else $error("ready not restored");

    // Reset leaves no digest pending.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("digest valid after reset");
endmodule

bind md5_message_digest md5_checker u_md5_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_digest_a (o_digest_a)
);

/* test/tb_md5_message_digest.sv */
// Testbench for the MD5 digest block: random byte streams checked against a local predictor.
`timescale 1ns / 1ps
module tb_md5_message_digest;

    localparam int unsigned CYCLE_LIMIT = 2000000;
    localparam logic [1:0] CMD_IGNORED = 2'd3;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } t_digest;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_cmd;
    logic [7:0]  i_data_byte;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_digest_a;
    logic [31:0] o_digest_b;
    logic [31:0] o_digest_c;
    logic [31:0] o_digest_d;

    int unsigned error_count;
    int unsigned cycle_count;

    md5_message_digest i_dut (.*);

    // One line per mismatch, counted.
    task automatic report_mismatch(input string what);
        error_count++;
        $display("mismatch @%0t: %s", $realtime, what);
    endtask

    // Tracks the hashing state and keeps the queue of pending digests.
    class digest_scoreboard;
        logic [31:0] chain[4];
        logic [7:0]  buffer[64];
        int unsigned fill;
        logic [60:0] byte_count;
        t_digest     pending_digests[$];

        function new();
            restart();
        endfunction

        function void restart();
            chain[0] = md5_pkg::INIT_A; chain[1] = md5_pkg::INIT_B;
            chain[2] = md5_pkg::INIT_C; chain[3] = md5_pkg::INIT_D;
            fill = 0;
            byte_count = '0;
        endfunction

        function void compress();
            logic [31:0] w[16];
            logic [31:0] a, b, c, d, f, t;
            int rot[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
            int g, grp, s;
            for (int i = 0; i < 16; i++)
                w[i] = {buffer[4*i+3], buffer[4*i+2], buffer[4*i+1], buffer[4*i]};
            a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
            for (int i = 0; i < 64; i++) begin
                grp = i / 16;
                case (grp)
                    0: begin f = d ^ (b & (c ^ d)); g = i; end
                    1: begin f = c ^ (d & (b ^ c)); g = (5 * i + 1) % 16; end
                    2: begin f = b ^ c ^ d;         g = (3 * i + 5) % 16; end
                    default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
                endcase
                t = a + f + w[g] + md5_pkg::round_k(6'(i));
                s = rot[grp * 4 + i % 4];
                t = b + ((t << s) | (t >> (32 - s)));
                a = d; d = c; c = b; b = t;
            end
            chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
        endfunction

        function void absorb(logic [7:0] v);
            buffer[fill] = v;
            fill++;
            byte_count++;
            if (fill == 64) begin
                compress();
                fill = 0;
            end
        endfunction

        function void finish();
            logic [63:0] bits;
            bits = {byte_count, 3'b000};
            buffer[fill] = md5_pkg::PAD_BYTE;
            for (int i = fill + 1; i < 64; i++) buffer[i] = 8'h00;
            if (fill >= 56) begin
                compress();
                for (int i = 0; i < 56; i++) buffer[i] = 8'h00;
            end
            for (int i = 0; i < 8; i++) buffer[56 + i] = bits[8*i +: 8];
            compress();
            pending_digests.push_back({chain[0], chain[1], chain[2], chain[3]});
            restart();
        endfunction

        // Accepted input transaction.
        function void note_input(logic [1:0] cmd, logic [7:0] data);
            case (cmd)
                md5_pkg::CMD_BYTE:     absorb(data);
                md5_pkg::CMD_BYTE_END: begin absorb(data); finish(); end
                md5_pkg::CMD_END:      finish();
                default: ;
            endcase
        endfunction

        // Accepted output transaction against the oldest pending digest.
        task check_digest(t_digest got);
            t_digest want;
            if (pending_digests.size() == 0) begin
                report_mismatch("digest with none expected");
                return;
            end
            want = pending_digests.pop_front();
            if (got.a !== want.a) report_mismatch($sformatf("a %h want %h", got.a, want.a));
            if (got.b !== want.b) report_mismatch($sformatf("b %h want %h", got.b, want.b));
            if (got.c !== want.c) report_mismatch($sformatf("c %h want %h", got.c, want.c));
            if (got.d !== want.d) report_mismatch($sformatf("d %h want %h", got.d, want.d));
        endtask
    endclass

    digest_scoreboard sb;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Monitors both channels at each edge.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && i_valid && o_ready) sb.note_input(i_cmd, i_data_byte);
        if (i_rst_n && o_valid && i_ready)
            sb.check_digest({o_digest_a, o_digest_b, o_digest_c, o_digest_d});
    end

    // Timeout watchdog.
    always @(posedge i_clk) begin
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: random stall before each result, sometimes none at all.
    initial begin
        int unsigned stall;
        bit          eager;
        i_ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            eager = ($urandom_range(0, 3) == 0);
            stall = eager ? 0 : $urandom_range(0, 15);
            repeat (stall) @(posedge i_clk);
            i_ready <= 1'b1;
            @(posedge i_clk iff o_valid);
            if (!eager || $urandom_range(0, 7) == 0) i_ready <= 1'b0;
        end
    end

    bit burst_mode;

    // Sends one transaction; the gap before it comes from a random draw.
    task automatic send(input logic [1:0] cmd, input logic [7:0] data);
        int unsigned gap;
        gap = burst_mode ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_cmd       <= cmd;
        i_data_byte <= data;
        @(posedge i_clk iff o_ready);
    endtask

    // A message of len bytes; the last one either carries the end or a bare end follows.
    task automatic send_message(input int unsigned len, input bit bare_end);
        for (int unsigned i = 0; i < len; i++) begin
            if (i == len - 1 && !bare_end) send(md5_pkg::CMD_BYTE_END, 8'($urandom));
            else send(md5_pkg::CMD_BYTE, 8'($urandom));
        end
        if (bare_end) send(md5_pkg::CMD_END, 8'($urandom));
    endtask

    // Holds the sender off until every expected digest has come back.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_digests.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int unsigned sent, len;
        bit          bare;
        sb = new();
        error_count = 0;
        cycle_count = 0;
        burst_mode  = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_cmd       = md5_pkg::CMD_BYTE;
        i_data_byte = 8'h00;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty message, ignored command, byte extremes, ending byte.
        send(md5_pkg::CMD_END, 8'hff);
        send(CMD_IGNORED, 8'h5a);
        send(md5_pkg::CMD_BYTE, 8'h00);
        send(md5_pkg::CMD_BYTE, 8'hff);
        send(CMD_IGNORED, 8'hff);
        send(md5_pkg::CMD_BYTE_END, 8'haa);
        send(md5_pkg::CMD_BYTE_END, 8'h55);
        // Full 64-byte block finished by the ending byte.
        for (int i = 0; i < 63; i++) send(md5_pkg::CMD_BYTE, 8'(i * 4 + 1));
        send(md5_pkg::CMD_BYTE_END, 8'h80);
        // 56 pending bytes: padding needs an extra block.
        for (int i = 0; i < 56; i++) send(md5_pkg::CMD_BYTE, 8'hff);
        send(md5_pkg::CMD_END, 8'h00);

        // Sender holds off until every digest has come back.
        drain();

        // Random messages; lengths often around block edges, a few longer.
        sent = 0;
        while (sent < 1200) begin
            burst_mode = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 5))
                0: len = $urandom_range(0, 8);
                1: len = $urandom_range(52, 72);
                2: len = $urandom_range(116, 130);
                3: len = $urandom_range(0, 200);
                default: len = $urandom_range(1, 40);
            endcase
            if ($urandom_range(0, 9) == 0) begin
                send(CMD_IGNORED, 8'($urandom));
                sent++;
            end
            if (len == 0) begin
                send(md5_pkg::CMD_END, 8'($urandom));
                sent++;
            end else begin
                bare = 1'($urandom_range(0, 1));
                send_message(len, bare);
                sent += len + (bare ? 1 : 0);
            end
            if ($urandom_range(0, 15) == 0) drain();
        end

        drain();
        repeat (300) @(posedge i_clk);
        if (error_count == 0 && sb.pending_digests.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/md5_pkg.sv
hw/rtl/md5_ram.sv
hw/rtl/md5_datapath.sv
hw/rtl/md5_ctrl.sv
hw/rtl/md5_message_digest.sv
hw/rtl/md5_checker.sv
test/tb_md5_message_digest.sv
